// File: rtl/core/sample_moment_statistics_macros.svh
// -----------------------------------------------------------------------------
// Sample moment statistics assertion macros
// Shorthand for clocked assertions used by the port checker.
// -----------------------------------------------------------------------------
`ifndef SAMPLE_MOMENT_STATISTICS_MACROS_SVH
`define SAMPLE_MOMENT_STATISTICS_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define SMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SMS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sms_pkg.sv
// -----------------------------------------------------------------------------
// sms_pkg
// Widths, datapath operations and control/status bundles for the block.
// -----------------------------------------------------------------------------
`default_nettype none
package sms_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SAMPLE_W    = 32;
  localparam int SUM_W       = SAMPLE_W + CNT_W;
  localparam int MN_W        = SUM_W + 2;
  localparam int S2_W        = 64 + CNT_W;
  localparam int DEN_W       = 32 + CNT_W;
  localparam int NUM_W       = 33 + CNT_W;
  localparam int SUM4_W      = 48 + CNT_W;
  localparam int SUM3_W      = 41 + CNT_W;
  localparam int Z_W         = 24;
  localparam int DVD_W       = S2_W;
  localparam int DVS_W       = DEN_W;
  localparam int DCNT_W      = $clog2(DVD_W + 1);

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MEAN_GO,
    OP_MEAN_TAKE,
    OP_DIFF,
    OP_MUL_DD,
    OP_S2ACC,
    OP_VAR_GO,
    OP_VAR_TAKE,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_SQRT_TAKE,
    OP_Z_GO,
    OP_Z_TAKE,
    OP_MUL_AA,
    OP_Z2,
    OP_MUL_ZA,
    OP_Z3,
    OP_MUL_ZZ,
    OP_Z4,
    OP_MUL_PA,
    OP_PACC,
    OP_R1_GO,
    OP_R1_TAKE,
    OP_KURT_GO,
    OP_KURT_TAKE,
    OP_SKEW_GO,
    OP_SKEW_TAKE,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [5:0] {
    ST_LOAD,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MEAN_TAKE,
    ST_P1_RD,
    ST_P1_DIFF,
    ST_P1_SQ,
    ST_P1_ACC,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_VAR_TAKE,
    ST_SQRT_INIT,
    ST_SQRT_RUN,
    ST_SQRT_TAKE,
    ST_P2_RD,
    ST_P2_DIFF,
    ST_Z_GO,
    ST_Z_WAIT,
    ST_Z_TAKE,
    ST_MUL_AA,
    ST_Z2,
    ST_MUL_ZA,
    ST_Z3,
    ST_MUL_ZZ,
    ST_Z4,
    ST_MUL_PA,
    ST_PACC,
    ST_R1_GO,
    ST_R1_WAIT,
    ST_R1_TAKE,
    ST_KURT_GO,
    ST_KURT_WAIT,
    ST_KURT_TAKE,
    ST_SKEW_GO,
    ST_SKEW_WAIT,
    ST_SKEW_TAKE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic idx_last;
    logic sd_zero;
    logic den_zero;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/sms_ram.sv
// -----------------------------------------------------------------------------
// sms_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none
module sms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/sms_div.sv
// -----------------------------------------------------------------------------
// sms_div
// Restoring unsigned divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
`default_nettype none
module sms_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [sms_pkg::DVD_W-1:0] dividend,
  input  logic [sms_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [sms_pkg::DVD_W-1:0] quotient
);
  import sms_pkg::*;

  logic [DVD_W-1:0]  q_r, q_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DVS_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, q_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = DCNT_W'(DVD_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
      q_nxt   = {q_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

// File: rtl/core/sms_datapath.sv
// -----------------------------------------------------------------------------
// sms_datapath
// Sample store, accumulators, shared multiplier, divider and square root.
// -----------------------------------------------------------------------------
`default_nettype none
module sms_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  sms_pkg::dp_cmd_t  cmd,
  input  logic [31:0]       in_sample,
  output sms_pkg::dp_stat_t stat,
  output logic              out_valid,
  output logic [31:0]       out_mean,
  output logic [31:0]       out_sd,
  output logic [31:0]       out_r1,
  output logic [31:0]       out_kurt,
  output logic [31:0]       out_skew,
  output logic              out_zero,
  output logic              out_drop
);
  import sms_pkg::*;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              drop_r, drop_nxt;
  logic [31:0]       mean_r, mean_nxt;
  logic              mean_neg_r, mean_neg_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [31:0]       dmag_r, dmag_nxt;
  logic              dneg_r, dneg_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic [S2_W-1:0]   s2_r, s2_nxt;
  logic [63:0]       var_r, var_nxt;
  logic [63:0]       sq_v_r, sq_v_nxt;
  logic [63:0]       sq_res_r, sq_res_nxt;
  logic [63:0]       sq_bit_r, sq_bit_nxt;
  logic [31:0]       sd_r, sd_nxt;
  logic              zero_r, zero_nxt;
  logic [Z_W-1:0]    a_r, a_nxt;
  logic [Z_W-1:0]    aprev_r, aprev_nxt;
  logic              negprev_r, negprev_nxt;
  logic [31:0]       z2_r, z2_nxt;
  logic [SUM4_W-1:0] sum4_r, sum4_nxt;
  logic [SUM3_W-1:0] sum3_r, sum3_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [31:0]       r1_r, r1_nxt;
  logic [31:0]       kurt_r, kurt_nxt;
  logic [31:0]       skew_r, skew_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [31:0]       omean_r, omean_nxt;
  logic [31:0]       osd_r, osd_nxt;
  logic [31:0]       or1_r, or1_nxt;
  logic [31:0]       okurt_r, okurt_nxt;
  logic [31:0]       oskew_r, oskew_nxt;
  logic              ozero_r, ozero_nxt;
  logic              odrop_r, odrop_nxt;

  logic              ram_we;
  logic [31:0]       ram_rdata;
  logic              div_go;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_prod;
  logic [MN_W-1:0]   mean_num, mean_mag;
  logic [CNT_W:0]    mean_den;
  logic [32:0]       diff, diff_abs;
  logic [63:0]       sq_trial;
  logic              idx_last;
  logic [SUM3_W-1:0] sum3_mag;
  logic [NUM_W-1:0]  num_mag;

  sms_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[ADDR_W-1:0]),
    .wdata(in_sample),
    .raddr(idx_r[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  sms_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (div_go),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quotient(div_q)
  );

  assign mul_prod = mul_a * mul_b;
  assign mean_num = {sum_r[SUM_W-1], sum_r, 1'b0} + MN_W'(count_r);
  assign mean_mag = mean_num[MN_W-1] ? (MN_W'(0) - mean_num) : mean_num;
  assign mean_den = {count_r, 1'b0};
  assign diff     = {ram_rdata[31], ram_rdata} - {mean_r[31], mean_r};
  assign diff_abs = diff[32] ? (33'd0 - diff) : diff;
  assign sq_trial = sq_res_r + sq_bit_r;
  assign idx_last = (idx_r + CNT_W'(1)) == count_r;
  assign sum3_mag = sum3_r[SUM3_W-1] ? (SUM3_W'(0) - sum3_r) : sum3_r;
  assign num_mag  = num_r[NUM_W-1] ? (NUM_W'(0) - num_r) : num_r;

  always_comb begin
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    drop_nxt     = drop_r;
    mean_nxt     = mean_r;
    mean_neg_nxt = mean_neg_r;
    idx_nxt      = idx_r;
    dmag_nxt     = dmag_r;
    dneg_nxt     = dneg_r;
    prod_nxt     = prod_r;
    s2_nxt       = s2_r;
    var_nxt      = var_r;
    sq_v_nxt     = sq_v_r;
    sq_res_nxt   = sq_res_r;
    sq_bit_nxt   = sq_bit_r;
    sd_nxt       = sd_r;
    zero_nxt     = zero_r;
    a_nxt        = a_r;
    aprev_nxt    = aprev_r;
    negprev_nxt  = negprev_r;
    z2_nxt       = z2_r;
    sum4_nxt     = sum4_r;
    sum3_nxt     = sum3_r;
    den_nxt      = den_r;
    num_nxt      = num_r;
    r1_nxt       = r1_r;
    kurt_nxt     = kurt_r;
    skew_nxt     = skew_r;
    ovalid_nxt   = 1'b0;
    omean_nxt    = omean_r;
    osd_nxt      = osd_r;
    or1_nxt      = or1_r;
    okurt_nxt    = okurt_r;
    oskew_nxt    = oskew_r;
    ozero_nxt    = ozero_r;
    odrop_nxt    = odrop_r;
    ram_we       = 1'b0;
    div_go       = 1'b0;
    div_dvd      = '0;
    div_dvs      = '0;
    mul_a        = '0;
    mul_b        = '0;
    case (cmd.op)
      OP_LOAD: begin
        if (count_r < CNT_W'(MAX_SAMPLES)) begin
          ram_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          sum_nxt   = sum_r + {{(SUM_W-32){in_sample[31]}}, in_sample};
        end else begin
          drop_nxt = 1'b1;
        end
      end
      OP_MEAN_GO: begin
        // floor of a negative quotient: divide (|N| + D - 1) and negate
        div_go       = 1'b1;
        div_dvd      = mean_num[MN_W-1] ?
                       DVD_W'(mean_mag) + DVD_W'(mean_den) - DVD_W'(1) : DVD_W'(mean_mag);
        div_dvs      = DVS_W'(mean_den);
        mean_neg_nxt = mean_num[MN_W-1];
      end
      OP_MEAN_TAKE: begin
        mean_nxt = mean_neg_r ? (32'd0 - div_q[31:0]) : div_q[31:0];
        idx_nxt  = '0;
        s2_nxt   = '0;
      end
      OP_DIFF: begin
        dneg_nxt = diff[32];
        dmag_nxt = diff_abs[31:0];
      end
      OP_MUL_DD: begin
        mul_a    = dmag_r;
        mul_b    = dmag_r;
        prod_nxt = mul_prod;
      end
      OP_S2ACC: begin
        s2_nxt  = s2_r + S2_W'(prod_r);
        idx_nxt = idx_r + CNT_W'(1);
      end
      OP_VAR_GO: begin
        div_go  = 1'b1;
        div_dvd = DVD_W'(s2_r);
        div_dvs = DVS_W'(count_r);
      end
      OP_VAR_TAKE: begin
        var_nxt = (|div_q[DVD_W-1:64]) ? '1 : div_q[63:0];
      end
      OP_SQRT_INIT: begin
        sq_v_nxt   = var_r;
        sq_res_nxt = '0;
        sq_bit_nxt = 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sq_bit_r != 64'd0) begin
          if (sq_v_r >= sq_trial) begin
            sq_v_nxt   = sq_v_r - sq_trial;
            sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_nxt = sq_res_r >> 1;
          end
          sq_bit_nxt = sq_bit_r >> 2;
        end
      end
      OP_SQRT_TAKE: begin
        sd_nxt   = sq_res_r[31:0];
        zero_nxt = (sq_res_r == 64'd0);
        idx_nxt  = '0;
        sum4_nxt = '0;
        sum3_nxt = '0;
        den_nxt  = '0;
        num_nxt  = '0;
        r1_nxt   = '0;
        kurt_nxt = '0;
        skew_nxt = '0;
      end
      OP_Z_GO: begin
        div_go  = 1'b1;
        div_dvd = (DVD_W'(dmag_r) << 17) + DVD_W'(sd_r);
        div_dvs = DVS_W'({sd_r, 1'b0});
      end
      OP_Z_TAKE: begin
        a_nxt = (|div_q[DVD_W-1:Z_W]) ? '1 : div_q[Z_W-1:0];
      end
      OP_MUL_AA: begin
        mul_a    = 32'(a_r);
        mul_b    = 32'(a_r);
        prod_nxt = mul_prod;
      end
      OP_Z2: begin
        z2_nxt = prod_r[47:16];
        if (!idx_last) begin
          den_nxt = den_r + DEN_W'(prod_r[47:16]);
        end
      end
      OP_MUL_ZA: begin
        mul_a    = z2_r;
        mul_b    = 32'(a_r);
        prod_nxt = mul_prod;
      end
      OP_Z3: begin
        sum3_nxt = dneg_r ? (sum3_r - SUM3_W'(prod_r[55:16]))
                          : (sum3_r + SUM3_W'(prod_r[55:16]));
      end
      OP_MUL_ZZ: begin
        mul_a    = z2_r;
        mul_b    = z2_r;
        prod_nxt = mul_prod;
      end
      OP_Z4: begin
        sum4_nxt = sum4_r + SUM4_W'(prod_r[63:16]);
      end
      OP_MUL_PA: begin
        mul_a    = 32'(aprev_r);
        mul_b    = 32'(a_r);
        prod_nxt = mul_prod;
      end
      OP_PACC: begin
        // lag product only once a previous sample exists
        if (idx_r != '0) begin
          num_nxt = (dneg_r != negprev_r) ? (num_r - NUM_W'(prod_r[47:16]))
                                          : (num_r + NUM_W'(prod_r[47:16]));
        end
        aprev_nxt   = a_r;
        negprev_nxt = dneg_r;
        idx_nxt     = idx_r + CNT_W'(1);
      end
      OP_R1_GO: begin
        div_go  = 1'b1;
        div_dvd = DVD_W'(num_mag) << 24;
        div_dvs = DVS_W'(den_r);
      end
      OP_R1_TAKE: begin
        if (num_r[NUM_W-1]) begin
          r1_nxt = (|div_q[DVD_W-1:31]) ? 32'h8000_0000 : (32'd0 - div_q[31:0]);
        end else begin
          r1_nxt = (|div_q[DVD_W-1:31]) ? 32'h7FFF_FFFF : div_q[31:0];
        end
      end
      OP_KURT_GO: begin
        div_go  = 1'b1;
        div_dvd = DVD_W'(sum4_r);
        div_dvs = DVS_W'(count_r);
      end
      OP_KURT_TAKE: begin
        kurt_nxt = (|div_q[DVD_W-1:32]) ? '1 : div_q[31:0];
      end
      OP_SKEW_GO: begin
        div_go  = 1'b1;
        div_dvd = DVD_W'(sum3_mag);
        div_dvs = DVS_W'(count_r);
      end
      OP_SKEW_TAKE: begin
        if (sum3_r[SUM3_W-1]) begin
          skew_nxt = (|div_q[DVD_W-1:31]) ? 32'h8000_0000 : (32'd0 - div_q[31:0]);
        end else begin
          skew_nxt = (|div_q[DVD_W-1:31]) ? 32'h7FFF_FFFF : div_q[31:0];
        end
      end
      OP_EMIT: begin
        ovalid_nxt = 1'b1;
        omean_nxt  = mean_r;
        osd_nxt    = sd_r;
        or1_nxt    = r1_r;
        okurt_nxt  = kurt_r;
        oskew_nxt  = skew_r;
        ozero_nxt  = zero_r;
        odrop_nxt  = drop_r;
        count_nxt  = '0;
        sum_nxt    = '0;
        drop_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sum_r    <= '0;
      drop_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      drop_r   <= drop_nxt;
      ovalid_r <= ovalid_nxt;
    end
    mean_r     <= mean_nxt;
    mean_neg_r <= mean_neg_nxt;
    idx_r      <= idx_nxt;
    dmag_r     <= dmag_nxt;
    dneg_r     <= dneg_nxt;
    prod_r     <= prod_nxt;
    s2_r       <= s2_nxt;
    var_r      <= var_nxt;
    sq_v_r     <= sq_v_nxt;
    sq_res_r   <= sq_res_nxt;
    sq_bit_r   <= sq_bit_nxt;
    sd_r       <= sd_nxt;
    zero_r     <= zero_nxt;
    a_r        <= a_nxt;
    aprev_r    <= aprev_nxt;
    negprev_r  <= negprev_nxt;
    z2_r       <= z2_nxt;
    sum4_r     <= sum4_nxt;
    sum3_r     <= sum3_nxt;
    den_r      <= den_nxt;
    num_r      <= num_nxt;
    r1_r       <= r1_nxt;
    kurt_r     <= kurt_nxt;
    skew_r     <= skew_nxt;
    omean_r    <= omean_nxt;
    osd_r      <= osd_nxt;
    or1_r      <= or1_nxt;
    okurt_r    <= okurt_nxt;
    oskew_r    <= oskew_nxt;
    ozero_r    <= ozero_nxt;
    odrop_r    <= odrop_nxt;
  end

  assign stat.div_done  = div_done;
  assign stat.sqrt_done = (sq_bit_r == 64'd0);
  assign stat.idx_last  = idx_last;
  assign stat.sd_zero   = (sq_res_r == 64'd0);
  assign stat.den_zero  = (den_r == '0);

  assign out_valid = ovalid_r;
  assign out_mean  = omean_r;
  assign out_sd    = osd_r;
  assign out_r1    = or1_r;
  assign out_kurt  = okurt_r;
  assign out_skew  = oskew_r;
  assign out_zero  = ozero_r;
  assign out_drop  = odrop_r;

endmodule
`default_nettype wire

// File: rtl/core/sms_ctrl.sv
// -----------------------------------------------------------------------------
// sms_ctrl
// Sequencer: load phase, mean, two passes over the store, final divides.
// -----------------------------------------------------------------------------
`default_nettype none
module sms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              last,
  input  sms_pkg::dp_stat_t stat,
  output logic              busy,
  output sms_pkg::dp_cmd_t  cmd
);
  import sms_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:      if (start && last) state_nxt = ST_MEAN_GO;
      ST_MEAN_GO:   state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (stat.div_done) state_nxt = ST_MEAN_TAKE;
      ST_MEAN_TAKE: state_nxt = ST_P1_RD;
      ST_P1_RD:     state_nxt = ST_P1_DIFF;
      ST_P1_DIFF:   state_nxt = ST_P1_SQ;
      ST_P1_SQ:     state_nxt = ST_P1_ACC;
      ST_P1_ACC:    state_nxt = stat.idx_last ? ST_VAR_GO : ST_P1_RD;
      ST_VAR_GO:    state_nxt = ST_VAR_WAIT;
      ST_VAR_WAIT:  if (stat.div_done) state_nxt = ST_VAR_TAKE;
      ST_VAR_TAKE:  state_nxt = ST_SQRT_INIT;
      ST_SQRT_INIT: state_nxt = ST_SQRT_RUN;
      ST_SQRT_RUN:  if (stat.sqrt_done) state_nxt = ST_SQRT_TAKE;
      ST_SQRT_TAKE: state_nxt = stat.sd_zero ? ST_EMIT : ST_P2_RD;
      ST_P2_RD:     state_nxt = ST_P2_DIFF;
      ST_P2_DIFF:   state_nxt = ST_Z_GO;
      ST_Z_GO:      state_nxt = ST_Z_WAIT;
      ST_Z_WAIT:    if (stat.div_done) state_nxt = ST_Z_TAKE;
      ST_Z_TAKE:    state_nxt = ST_MUL_AA;
      ST_MUL_AA:    state_nxt = ST_Z2;
      ST_Z2:        state_nxt = ST_MUL_ZA;
      ST_MUL_ZA:    state_nxt = ST_Z3;
      ST_Z3:        state_nxt = ST_MUL_ZZ;
      ST_MUL_ZZ:    state_nxt = ST_Z4;
      ST_Z4:        state_nxt = ST_MUL_PA;
      ST_MUL_PA:    state_nxt = ST_PACC;
      ST_PACC: begin
        if (stat.idx_last) begin
          state_nxt = stat.den_zero ? ST_KURT_GO : ST_R1_GO;
        end else begin
          state_nxt = ST_P2_RD;
        end
      end
      ST_R1_GO:     state_nxt = ST_R1_WAIT;
      ST_R1_WAIT:   if (stat.div_done) state_nxt = ST_R1_TAKE;
      ST_R1_TAKE:   state_nxt = ST_KURT_GO;
      ST_KURT_GO:   state_nxt = ST_KURT_WAIT;
      ST_KURT_WAIT: if (stat.div_done) state_nxt = ST_KURT_TAKE;
      ST_KURT_TAKE: state_nxt = ST_SKEW_GO;
      ST_SKEW_GO:   state_nxt = ST_SKEW_WAIT;
      ST_SKEW_WAIT: if (stat.div_done) state_nxt = ST_SKEW_TAKE;
      ST_SKEW_TAKE: state_nxt = ST_EMIT;
      ST_EMIT:      state_nxt = ST_LOAD;
      default:      state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd.op = OP_IDLE;
    case (state_r)
      ST_LOAD:      if (start) cmd.op = OP_LOAD;
      ST_MEAN_GO:   cmd.op = OP_MEAN_GO;
      ST_MEAN_TAKE: cmd.op = OP_MEAN_TAKE;
      ST_P1_DIFF:   cmd.op = OP_DIFF;
      ST_P1_SQ:     cmd.op = OP_MUL_DD;
      ST_P1_ACC:    cmd.op = OP_S2ACC;
      ST_VAR_GO:    cmd.op = OP_VAR_GO;
      ST_VAR_TAKE:  cmd.op = OP_VAR_TAKE;
      ST_SQRT_INIT: cmd.op = OP_SQRT_INIT;
      ST_SQRT_RUN:  cmd.op = OP_SQRT_STEP;
      ST_SQRT_TAKE: cmd.op = OP_SQRT_TAKE;
      ST_P2_DIFF:   cmd.op = OP_DIFF;
      ST_Z_GO:      cmd.op = OP_Z_GO;
      ST_Z_TAKE:    cmd.op = OP_Z_TAKE;
      ST_MUL_AA:    cmd.op = OP_MUL_AA;
      ST_Z2:        cmd.op = OP_Z2;
      ST_MUL_ZA:    cmd.op = OP_MUL_ZA;
      ST_Z3:        cmd.op = OP_Z3;
      ST_MUL_ZZ:    cmd.op = OP_MUL_ZZ;
      ST_Z4:        cmd.op = OP_Z4;
      ST_MUL_PA:    cmd.op = OP_MUL_PA;
      ST_PACC:      cmd.op = OP_PACC;
      ST_R1_GO:     cmd.op = OP_R1_GO;
      ST_R1_TAKE:   cmd.op = OP_R1_TAKE;
      ST_KURT_GO:   cmd.op = OP_KURT_GO;
      ST_KURT_TAKE: cmd.op = OP_KURT_TAKE;
      ST_SKEW_GO:   cmd.op = OP_SKEW_GO;
      ST_SKEW_TAKE: cmd.op = OP_SKEW_TAKE;
      ST_EMIT:      cmd.op = OP_EMIT;
      default:      cmd.op = OP_IDLE;
    endcase
  end

  assign busy = (state_r != ST_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sample_moment_statistics.sv
// -----------------------------------------------------------------------------
// sample_moment_statistics
// Mean, standard deviation, lag-1 autocorrelation, kurtosis and skewness
// of a run of Q16.16 samples.
// -----------------------------------------------------------------------------
// Drive one sample per beat with start; a beat is taken on a rising edge with
// start high and busy low. While loading, busy stays low and a sample can be
// taken every cycle; samples past the 1024-entry store are dropped and flagged.
// The beat with in_last_sample high closes the run: busy rises and the block
// computes over the n stored samples (when the spread is zero, the second pass
// and the final divides are skipped). That time is set mostly by the shared
// restoring divider, which yields one quotient bit per cycle (each divide runs
// through start, 75 steps, done and take): one divide per sample in the second
// pass, plus the mean, variance and up to three final divides; the first pass
// reads, takes the difference, squares and accumulates each sample, and then the
// square root is computed. The result then
// shows on the out_ ports for exactly one cycle with out_valid high, and busy
// drops in that same cycle. The receiver cannot stall: capture the result in
// the cycle out_valid is high, it is not held.
// -----------------------------------------------------------------------------
`default_nettype none
module sample_moment_statistics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_sample,
  input  logic               in_last_sample,
  output logic               out_valid,
  output logic signed [31:0] out_sample_mean,
  output logic        [31:0] out_std_dev,
  output logic signed [31:0] out_lag_one_autocorr,
  output logic        [31:0] out_kurtosis_value,
  output logic signed [31:0] out_skewness_value,
  output logic               out_zero_spread,
  output logic               out_overflow_flag
);
  import sms_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] mean_w, r1_w, skew_w;

  // sequencer: owns the handshake and walks the closing passes
  sms_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .last (in_last_sample),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  // store, accumulators and arithmetic units
  sms_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_sample(in_sample),
    .stat     (stat),
    .out_valid(out_valid),
    .out_mean (mean_w),
    .out_sd   (out_std_dev),
    .out_r1   (r1_w),
    .out_kurt (out_kurtosis_value),
    .out_skew (skew_w),
    .out_zero (out_zero_spread),
    .out_drop (out_overflow_flag)
  );

  assign out_sample_mean      = mean_w;
  assign out_lag_one_autocorr = r1_w;
  assign out_skewness_value   = skew_w;

endmodule
`default_nettype wire

// File: rtl/core/sample_moment_statistics_checker.sv
// -----------------------------------------------------------------------------
// sample_moment_statistics_checker
// Port-level checks on handshake timing and result consistency.
// -----------------------------------------------------------------------------
`default_nettype none
`include "sample_moment_statistics_macros.svh"
module sample_moment_statistics_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_last_sample,
  input logic        out_valid,
  input logic [31:0] out_lag_one_autocorr,
  input logic [31:0] out_kurtosis_value,
  input logic [31:0] out_skewness_value,
  input logic        out_zero_spread
);

  logic moments_zero;

  assign moments_zero = (out_kurtosis_value == 32'd0) && (out_skewness_value == 32'd0) &&
                        (out_lag_one_autocorr == 32'd0);

  `SMS_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one beat")
  `SMS_ASSERT_NEXT(a_load_ready, start && !busy && !in_last_sample, !busy, "busy after plain sample")
  `SMS_ASSERT_NEXT(a_close_busy, start && !busy && in_last_sample, busy, "no busy after closing beat")
  `SMS_ASSERT_SAME(a_result_idle, out_valid, !busy, "result shown while still busy")
  `SMS_ASSERT_SAME(a_zero_spread, out_valid && out_zero_spread, moments_zero, "zero spread moments")

endmodule

bind sample_moment_statistics sample_moment_statistics_sva u_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_last_sample      (in_last_sample),
  .out_valid           (out_valid),
  .out_lag_one_autocorr(out_lag_one_autocorr),
  .out_kurtosis_value  (out_kurtosis_value),
  .out_skewness_value  (out_skewness_value),
  .out_zero_spread     (out_zero_spread)
);
`default_nettype wire
